### hw/rtl/stsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stsw_pkg;

  // Queue depths used as defaults by the top level.
  localparam int unsigned CmdDepthDef = 4;
  localparam int unsigned OutDepthDef = 8;

  // Display unit sizes in milliseconds.
  localparam logic [31:0] MsPerSec  = 32'd1000;
  localparam logic [31:0] MsPerMin  = 32'd60000;
  localparam logic [31:0] MsPerHour = 32'd3600000;

  // Reciprocals, floor(2^32 / unit). The quotient estimate taken from them is
  // at most one below the true quotient.
  localparam logic [31:0] RecipSec  = 32'((64'd1 << 32) / 64'd1000);
  localparam logic [31:0] RecipMin  = 32'((64'd1 << 32) / 64'd60000);
  localparam logic [31:0] RecipHour = 32'((64'd1 << 32) / 64'd3600000);

  typedef enum logic [3:0] {
    OP_QUERY     = 4'd0,
    OP_START     = 4'd1,
    OP_STOP      = 4'd2,
    OP_PAUSE     = 4'd3,
    OP_RESUME    = 4'd4,
    OP_RESET     = 4'd5,
    OP_CLEAR     = 4'd6,
    OP_RESTART   = 4'd7,
    OP_LAP       = 4'd8,
    OP_TGT_CHECK = 4'd9,
    OP_DUR_CHECK = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MIN  = 2'd1,
    UNIT_HOUR = 2'd2
  } unit_e;

  typedef enum logic [0:0] {
    REG_TARGET = 1'b0,
    REG_REPEAT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] now_ms;
    logic [31:0] check_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [31:0] lap_ms;
    logic [31:0] remaining_ms;
    logic [31:0] remaining_in_unit;
    logic [1:0]  unit;
    logic        target_reached;
    logic        duration_reached;
    logic        running;
    logic        paused;
  } out_item_t;

  // Classified command as it waits between front and back.
  typedef struct packed {
    op_e         op;
    logic [31:0] now_ms;
    logic [31:0] check_ms;
  } cmd_t;

  // Outcome of the execute stage, before the remaining-time math.
  typedef struct packed {
    logic [31:0] elapsed;
    logic [31:0] lap;
    logic        target_reached;
    logic        duration_reached;
    logic        running;
    logic        paused;
  } exec_res_t;

  function automatic logic [31:0] unit_size(unit_e u);
    logic [31:0] d;
    case (u)
      UNIT_HOUR: d = MsPerHour;
      UNIT_MIN:  d = MsPerMin;
      default:   d = MsPerSec;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] unit_recip(unit_e u);
    logic [31:0] r;
    case (u)
      UNIT_HOUR: r = RecipHour;
      UNIT_MIN:  r = RecipMin;
      default:   r = RecipSec;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/stopwatch_with_lap_and_target.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// command   in         push / full       in_item_i  (op, now_ms, check_ms)
// result    out        pop / empty       out_item_o (elapsed, lap, remaining, unit, flags)
// config    in         cfg_we_i          cfg_idx_i selects target_ms or repeat_mode
//
// The block takes one command item per cycle and returns one result per cycle
// when neither side stalls. A result reaches the output queue once its command
// has passed through the command queue, the execute stage and the staged
// remaining-time pipeline, whose two reciprocal multiplications for the unit
// division set its depth. Reset clears the stopwatch state, both registers
// and both queues at once. When the output queue is backed up the execute
// stage stops drawing commands, and the command queue keeps taking items
// until it fills.

module stopwatch_with_lap_and_target #(
  parameter int unsigned CmdDepth = stsw_pkg::CmdDepthDef,
  parameter int unsigned OutDepth = stsw_pkg::OutDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command side.
  input  wire logic                push,
  output logic                     full,
  input  wire stsw_pkg::in_item_t  in_item_i,
  // Result side.
  output logic                     empty,
  input  wire logic                pop,
  output stsw_pkg::out_item_t      out_item_o,
  // Configuration writes.
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i
);

  localparam int unsigned ResvW = $clog2(OutDepth + 1);

  logic [31:0]         target_q;
  logic                repeat_q;

  stsw_pkg::cmd_t      cmd;
  logic                cmd_avail;
  logic                issue;
  logic                exec_valid;
  stsw_pkg::exec_res_t exec_res;
  logic                res_valid;
  stsw_pkg::out_item_t res_item;
  logic                out_pop;

  // Every item between the execute stage and the output queue owns a slot
  // there, so the pipeline itself never has to stall.
  logic [ResvW-1:0]    resv_q, resv_d;

  // Configuration registers. The user must change them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      repeat_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (stsw_pkg::reg_idx_e'(cfg_idx_i))
        stsw_pkg::REG_TARGET: target_q <= cfg_wdata_i;
        stsw_pkg::REG_REPEAT: repeat_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  stsw_front #(
    .CmdDepth(CmdDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item_i),
    .full_o (full),
    .take_i (issue),
    .cmd_o  (cmd),
    .avail_o(cmd_avail)
  );

  // A command issues only when a result slot is free for it.
  assign issue   = cmd_avail && (resv_q < ResvW'(OutDepth));
  assign out_pop = pop && !empty;

  always_comb begin
    resv_d = resv_q;
    if (issue && !out_pop) begin
      resv_d = resv_q + 1'b1;
    end else if (out_pop && !issue) begin
      resv_d = resv_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_q <= '0;
    end else begin
      resv_q <= resv_d;
    end
  end

  stsw_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .cmd_i   (cmd),
    .target_i(target_q),
    .repeat_i(repeat_q),
    .valid_o (exec_valid),
    .res_o   (exec_res)
  );

  stsw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exec_valid),
    .res_i   (exec_res),
    .target_i(target_q),
    .valid_o (res_valid),
    .item_o  (res_item)
  );

  stsw_fifo #(
    .Depth(OutDepth),
    .Width($bits(stsw_pkg::out_item_t))
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res_item),
    .full_o (),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire

### hw/rtl/stsw_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stsw_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/stsw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stsw_front #(
  parameter int unsigned CmdDepth = stsw_pkg::CmdDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire stsw_pkg::in_item_t item_i,
  output logic                    full_o,
  input  wire logic               take_i,
  output stsw_pkg::cmd_t          cmd_o,
  output logic                    avail_o
);

  stsw_pkg::cmd_t cmd_in;
  logic           empty;

  // Codes past the last defined command behave as a query.
  always_comb begin
    cmd_in.now_ms   = item_i.now_ms;
    cmd_in.check_ms = item_i.check_ms;
    if (item_i.op > 4'(stsw_pkg::OP_DUR_CHECK)) begin
      cmd_in.op = stsw_pkg::OP_QUERY;
    end else begin
      cmd_in.op = stsw_pkg::op_e'(item_i.op);
    end
  end

  stsw_fifo #(
    .Depth(CmdDepth),
    .Width($bits(stsw_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (take_i),
    .data_o (cmd_o),
    .empty_o(empty)
  );

  assign avail_o = !empty;

endmodule

`default_nettype wire

### hw/rtl/stsw_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module stsw_exec (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           issue_i,
  input  wire stsw_pkg::cmd_t cmd_i,
  input  wire logic [31:0]    target_i,
  input  wire logic           repeat_i,
  output logic                valid_o,
  output stsw_pkg::exec_res_t res_o
);

  logic [31:0] start_q, start_d, acc_q, acc_d, pstamp_q, pstamp_d, anchor_q, anchor_d;
  logic        run_q, run_d, pause_q, pause_d;
  logic [31:0] diff_run, diff_ps, el_cur, lap_end;
  logic        hit, restart;
  stsw_pkg::exec_res_t res_d;

  always_comb begin
    diff_run = cmd_i.now_ms - start_q;
    diff_ps  = pstamp_q - start_q;
    if (run_q) begin
      el_cur = acc_q + diff_run;
    end else if (pause_q) begin
      el_cur = acc_q + diff_ps;
    end else begin
      el_cur = acc_q;
    end
    hit     = (target_i != '0) && (el_cur >= target_i);
    lap_end = run_q ? cmd_i.now_ms : acc_q + start_q;

    start_d  = start_q;
    acc_d    = acc_q;
    pstamp_d = pstamp_q;
    anchor_d = anchor_q;
    run_d    = run_q;
    pause_d  = pause_q;
    restart  = 1'b0;

    res_d                  = '0;
    res_d.elapsed          = el_cur;

    case (cmd_i.op)
      stsw_pkg::OP_START: begin
        if (!run_q && !pause_q) begin
          start_d  = cmd_i.now_ms;
          anchor_d = cmd_i.now_ms;
          run_d    = 1'b1;
        end
      end
      stsw_pkg::OP_STOP: begin
        if (run_q) begin
          acc_d = el_cur;
          run_d = 1'b0;
        end
      end
      stsw_pkg::OP_PAUSE: begin
        if (run_q && !pause_q) begin
          pstamp_d = cmd_i.now_ms;
          pause_d  = 1'b1;
          run_d    = 1'b0;
        end
      end
      stsw_pkg::OP_RESUME: begin
        if (pause_q) begin
          start_d = start_q + (cmd_i.now_ms - pstamp_q);
          pause_d = 1'b0;
          run_d   = 1'b1;
        end
      end
      stsw_pkg::OP_RESET: begin
        // The accumulated part is dropped; a paused span still counts.
        if (!run_q) begin
          acc_d         = '0;
          res_d.elapsed = pause_q ? diff_ps : '0;
        end
      end
      stsw_pkg::OP_CLEAR: begin
        acc_d         = '0;
        start_d       = '0;
        pstamp_d      = '0;
        run_d         = 1'b0;
        pause_d       = 1'b0;
        res_d.elapsed = '0;
      end
      stsw_pkg::OP_RESTART: begin
        restart = 1'b1;
      end
      stsw_pkg::OP_LAP: begin
        res_d.lap = lap_end - anchor_q;
        anchor_d  = lap_end;
      end
      stsw_pkg::OP_TGT_CHECK: begin
        res_d.target_reached = hit;
        restart              = hit && repeat_i;
      end
      stsw_pkg::OP_DUR_CHECK: begin
        res_d.duration_reached = (el_cur >= cmd_i.check_ms);
      end
      default: begin
      end
    endcase

    // A restart clears the state, moves the lap anchor to the current stamp and starts afresh.
    if (restart) begin
      acc_d         = '0;
      pstamp_d      = '0;
      start_d       = cmd_i.now_ms;
      anchor_d      = cmd_i.now_ms;
      run_d         = 1'b1;
      pause_d       = 1'b0;
      res_d.elapsed = '0;
    end

    res_d.running = run_d;
    res_d.paused  = pause_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      acc_q    <= '0;
      pstamp_q <= '0;
      anchor_q <= '0;
      run_q    <= 1'b0;
      pause_q  <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid_o <= issue_i;
      if (issue_i) begin
        start_q  <= start_d;
        acc_q    <= acc_d;
        pstamp_q <= pstamp_d;
        anchor_q <= anchor_d;
        run_q    <= run_d;
        pause_q  <= pause_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      res_o <= res_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/stsw_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stsw_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire stsw_pkg::exec_res_t res_i,
  input  wire logic [31:0]         target_i,
  output logic                     valid_o,
  output stsw_pkg::out_item_t      item_o
);

  // Stage 2: remaining time and unit choice.
  logic                s2_valid_q;
  stsw_pkg::exec_res_t s2_res_q;
  logic [31:0]         s2_rem_q, rem_d;
  stsw_pkg::unit_e     s2_unit_q, unit_d;

  // Stage 3: quotient estimate from the reciprocal.
  logic                s3_valid_q;
  stsw_pkg::exec_res_t s3_res_q;
  logic [31:0]         s3_rem_q, s3_q0_q;
  stsw_pkg::unit_e     s3_unit_q;
  logic [63:0]         prod_est;

  // Stage 4: estimate times unit size, for the correction.
  logic                s4_valid_q;
  stsw_pkg::exec_res_t s4_res_q;
  logic [31:0]         s4_rem_q, s4_q0_q, s4_qd_q;
  stsw_pkg::unit_e     s4_unit_q;
  logic [63:0]         prod_back;

  logic [31:0]         resid;

  always_comb begin
    rem_d = (res_i.elapsed >= target_i) ? '0 : target_i - res_i.elapsed;
    if (rem_d >= stsw_pkg::MsPerHour) begin
      unit_d = stsw_pkg::UNIT_HOUR;
    end else if (rem_d >= stsw_pkg::MsPerMin) begin
      unit_d = stsw_pkg::UNIT_MIN;
    end else begin
      unit_d = stsw_pkg::UNIT_SEC;
    end
  end

  assign prod_est  = {32'd0, s2_rem_q} * {32'd0, stsw_pkg::unit_recip(s2_unit_q)};
  assign prod_back = {32'd0, s3_q0_q} * {32'd0, stsw_pkg::unit_size(s3_unit_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_res_q  <= res_i;
    s2_rem_q  <= rem_d;
    s2_unit_q <= unit_d;

    s3_res_q  <= s2_res_q;
    s3_rem_q  <= s2_rem_q;
    s3_unit_q <= s2_unit_q;
    s3_q0_q   <= prod_est[63:32];

    s4_res_q  <= s3_res_q;
    s4_rem_q  <= s3_rem_q;
    s4_unit_q <= s3_unit_q;
    s4_q0_q   <= s3_q0_q;
    s4_qd_q   <= prod_back[31:0];
  end

  // The estimate is low by at most one, so a single compare fixes it.
  assign resid = s4_rem_q - s4_qd_q;

  always_comb begin
    item_o.elapsed_ms        = s4_res_q.elapsed;
    item_o.lap_ms            = s4_res_q.lap;
    item_o.remaining_ms      = s4_rem_q;
    item_o.remaining_in_unit = (resid >= stsw_pkg::unit_size(s4_unit_q)) ?
                               s4_q0_q + 32'd1 : s4_q0_q;
    item_o.unit              = s4_unit_q;
    item_o.target_reached    = s4_res_q.target_reached;
    item_o.duration_reached  = s4_res_q.duration_reached;
    item_o.running           = s4_res_q.running;
    item_o.paused            = s4_res_q.paused;
  end

  assign valid_o = s4_valid_q;

endmodule

`default_nettype wire

### hw/rtl/stsw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stsw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                push,
  input wire logic                full,
  input wire logic                pop,
  input wire logic                empty,
  input wire stsw_pkg::out_item_t out_item_o
);

  logic [7:0] pending_q;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (acc_in && !acc_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (acc_out && !acc_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A result is only shown for an item that was taken and not yet answered.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != '0)
    else $error("result shown without an outstanding item");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_item_o.running && out_item_o.paused))
    else $error("running and paused both set");

  a_reached_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_item_o.target_reached && out_item_o.duration_reached))
    else $error("both reached flags set");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.unit == stsw_pkg::UNIT_SEC |-> out_item_o.remaining_in_unit < 32'd60)
    else $error("seconds value out of range");

endmodule

bind stopwatch_with_lap_and_target stsw_checker u_checker (.*);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

// Stopwatch testbench.
//
// Commands are queued up by the sequencing block at the bottom and handed to
// the block by a driver that works on the falling clock edge. A monitor on the
// rising edge sees every accepted command and every accepted result. For each
// accepted command it runs the stopwatch predictor, which keeps its own copy of
// the stamps, the flags and the two registers, and stores the predicted result.
// Each accepted result is compared field by field with the oldest prediction.
//
// The run starts with a short directed sequence under the reset register
// values. It is followed by random phases, each under its own target and
// repeat setting. Registers are only written while nothing is in flight.
// Both sides pause at random between items, with stretches of no pausing.
// Once in the run the receiver holds off for a long stretch, so that both
// queues inside the block fill up and the command side stalls.
module testbench;
  import stsw_pkg::*;

  // Codes 11 to 15 have no command of their own and must behave as a query.
  localparam logic [3:0] OpUnusedLo = 4'd11;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  localparam int unsigned RandPerPhase = 280;
  // Cycles to let pass after the last result.
  localparam int unsigned DrainCycles  = 12;
  // The receiver hold-off starts once this many results have been taken.
  localparam int unsigned HoldAt       = 500;
  localparam int unsigned HoldLen      = 300;
  // Cycles without any accepted item before the run is declared hung. The
  // longest correct stretch is the receiver hold-off above.
  localparam int unsigned WatchLimit   = 4000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    in_item_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  stopwatch_with_lap_and_target dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Commands waiting to be driven, and results predicted but not yet seen.
  in_item_t    cmd_backlog[$];
  out_item_t   pending_results[$];

  int unsigned items_total  = 0;  // commands queued so far
  int unsigned result_cnt   = 0;  // results taken that had a prediction
  int unsigned error_cnt    = 0;
  int unsigned stall_cycles = 0;  // cycles in a row with nothing accepted

  // Predictor state: the stopwatch itself and its two registers.
  logic [31:0] sw_start   = '0;
  logic [31:0] sw_accum   = '0;
  logic [31:0] sw_pause   = '0;
  logic [31:0] sw_anchor  = '0;
  logic        sw_run     = 1'b0;
  logic        sw_paused  = 1'b0;
  logic [31:0] cfg_target = '0;
  logic        cfg_repeat = 1'b0;

  function automatic logic [31:0] sw_elapsed(logic [31:0] now);
    if (sw_run) return sw_accum + (now - sw_start);
    if (sw_paused) return sw_accum + (sw_pause - sw_start);
    return sw_accum;
  endfunction

  // Clearing leaves the lap anchor alone.
  function automatic void sw_clear();
    sw_accum  = '0;
    sw_start  = '0;
    sw_pause  = '0;
    sw_run    = 1'b0;
    sw_paused = 1'b0;
  endfunction

  function automatic void sw_begin(logic [31:0] now);
    if (!sw_run && !sw_paused) begin
      sw_start  = now;
      sw_anchor = now;
      sw_run    = 1'b1;
    end
  endfunction

  // Applies one command to the predictor state and returns the result the
  // block must produce for it.
  function automatic out_item_t stopwatch_predict(in_item_t cmd);
    out_item_t   r;
    logic [31:0] now;
    logic [31:0] lap_end;
    logic [31:0] el;
    logic [31:0] rem;
    r   = '0;
    now = cmd.now_ms;
    case (op_e'(cmd.op))
      OP_START: sw_begin(now);
      OP_STOP: begin
        if (sw_run) begin
          sw_accum = sw_accum + (now - sw_start);
          sw_run   = 1'b0;
        end
      end
      OP_PAUSE: begin
        if (sw_run && !sw_paused) begin
          sw_pause  = now;
          sw_paused = 1'b1;
          sw_run    = 1'b0;
        end
      end
      OP_RESUME: begin
        if (sw_paused) begin
          sw_start  = sw_start + (now - sw_pause);
          sw_paused = 1'b0;
          sw_run    = 1'b1;
        end
      end
      OP_RESET: begin
        if (!sw_run) sw_accum = '0;
      end
      OP_CLEAR: sw_clear();
      OP_RESTART: begin
        sw_clear();
        sw_begin(now);
      end
      OP_LAP: begin
        // A stopped watch ends its lap at accumulated plus the start stamp.
        lap_end   = sw_run ? now : sw_accum + sw_start;
        r.lap_ms  = lap_end - sw_anchor;
        sw_anchor = lap_end;
      end
      OP_TGT_CHECK: begin
        if (cfg_target != '0 && sw_elapsed(now) >= cfg_target) begin
          r.target_reached = 1'b1;
          if (cfg_repeat) begin
            sw_clear();
            sw_begin(now);
          end
        end
      end
      OP_DUR_CHECK: r.duration_reached = (sw_elapsed(now) >= cmd.check_ms);
      default: ;
    endcase

    el  = sw_elapsed(now);
    rem = (el >= cfg_target) ? '0 : cfg_target - el;
    if (rem >= MsPerHour) begin
      r.unit              = UNIT_HOUR;
      r.remaining_in_unit = rem / MsPerHour;
    end else if (rem >= MsPerMin) begin
      r.unit              = UNIT_MIN;
      r.remaining_in_unit = rem / MsPerMin;
    end else begin
      r.unit              = UNIT_SEC;
      r.remaining_in_unit = rem / MsPerSec;
    end
    r.elapsed_ms   = el;
    r.remaining_ms = rem;
    r.running      = sw_run;
    r.paused       = sw_paused;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_cnt++;
    end
  endfunction

  // Draws how long a side waits before its next item. While a calm stretch
  // is running the wait is zero, so back-to-back traffic is exercised too.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Command driver. A command stays on the port until the monitor has seen
  // it accepted; only then does the gap before the next one start.
  bit          cmd_taken = 1'b0;
  int unsigned tx_gap    = 0;
  int unsigned tx_calm   = 0;

  always @(negedge clk_i) begin : cmd_driver
    logic nxt_push;
    if (rst_ni) begin
      nxt_push = push && !cmd_taken;
      if (!nxt_push) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_backlog.size() > 0) begin
          in_item_i <= cmd_backlog.pop_front();
          nxt_push = 1'b1;
          tx_gap   = draw_gap(tx_calm);
        end
      end
      cmd_taken = 1'b0;
      push <= nxt_push;
    end
  end

  // Result receiver. It waits a random number of cycles after each item, and
  // once in the run it holds off for a long stretch to back the block up.
  int unsigned rx_wait   = 0;
  int unsigned rx_calm   = 0;
  int unsigned rx_hold   = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin : result_receiver
    logic nxt_pop;
    if (rst_ni) begin
      if (!hold_done && result_cnt >= HoldAt) begin
        rx_hold   = HoldLen;
        hold_done = 1'b1;
      end
      nxt_pop = 1'b0;
      if (rx_hold > 0) rx_hold--;
      else if (rx_wait > 0) rx_wait--;
      else nxt_pop = 1'b1;
      pop <= nxt_pop;
    end
  end

  // Monitor: predicts on every accepted command, checks every accepted result
  // and keeps the count of idle cycles for the watchdog.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (push && !full) begin
        pending_results.push_back(stopwatch_predict(in_item_i));
        cmd_taken = 1'b1;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result item with no command waiting for it");
          error_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("elapsed_ms", want.elapsed_ms, out_item_o.elapsed_ms);
          check_field("lap_ms", want.lap_ms, out_item_o.lap_ms);
          check_field("remaining_ms", want.remaining_ms, out_item_o.remaining_ms);
          check_field("remaining_in_unit", want.remaining_in_unit,
                      out_item_o.remaining_in_unit);
          check_field("unit", 32'(want.unit), 32'(out_item_o.unit));
          check_field("target_reached", 32'(want.target_reached),
                      32'(out_item_o.target_reached));
          check_field("duration_reached", 32'(want.duration_reached),
                      32'(out_item_o.duration_reached));
          check_field("running", 32'(want.running), 32'(out_item_o.running));
          check_field("paused", 32'(want.paused), 32'(out_item_o.paused));
          result_cnt++;
        end
        rx_wait = draw_gap(rx_calm);
      end
      if ((push && !full) || (pop && !empty) || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Watchdog. The counter only moves on rising edges, so it is read on the
  // falling edge.
  initial begin : watchdog
    while (stall_cycles < WatchLimit) @(negedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic add_cmd(logic [3:0] op, logic [31:0] now, logic [31:0] chk);
    in_item_t cmd;
    cmd.op       = op;
    cmd.now_ms   = now;
    cmd.check_ms = chk;
    cmd_backlog.push_back(cmd);
    items_total++;
  endtask

  // Waits until every queued command has come back as a result, then lets the
  // pipeline settle.
  task automatic drain();
    while (result_cnt != items_total) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Writes both registers; only called while nothing is in flight.
  task automatic write_regs(logic [31:0] target, logic rep);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TARGET;
    cfg_wdata_i <= target;
    cfg_target   = target;
    @(negedge clk_i);
    cfg_idx_i   <= REG_REPEAT;
    cfg_wdata_i <= {31'd0, rep};
    cfg_repeat   = rep;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '1;
    // Hand the backlog over away from the driver's edge.
    @(posedge clk_i);
  endtask

  // One random phase. The time stamp mostly creeps forward so that elapsed
  // times stay near the target, with occasional large steps and jumps that
  // wrap the stamp.
  task automatic random_phase(inout logic [31:0] t_now);
    logic [3:0]  op;
    logic [31:0] chk;
    for (int i = 0; i < RandPerPhase; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t_now += $urandom_range(0, 50);
        4, 5, 6:    t_now += $urandom_range(0, 5000);
        7:          t_now += $urandom_range(0, 300000);
        8:          t_now += $urandom_range(0, 20000000);
        default:    t_now  = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: chk = $urandom_range(0, 10000);
        3, 4:    chk = $urandom;
        default: chk = $urandom_range(0, 20000000);
      endcase
      case ($urandom_range(0, 24))
        0:       op = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
        1, 2, 3: op = OP_TGT_CHECK;
        default: op = 4'($urandom_range(OP_QUERY, OP_DUR_CHECK));
      endcase
      add_cmd(op, t_now, chk);
    end
  endtask

  initial begin : sequencer
    logic [31:0] t_now;
    t_now = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence under the reset values: target zero, no repeat.
    add_cmd(OP_QUERY,     32'd0,    32'd0);
    add_cmd(OP_STOP,      32'd10,   32'd0);     // stop while not running
    add_cmd(OP_PAUSE,     32'd20,   32'd0);     // pause while not running
    add_cmd(OP_RESUME,    32'd30,   32'd0);     // resume while not paused
    add_cmd(OP_LAP,       32'd40,   32'd0);     // lap while not running
    add_cmd(OP_START,     32'd100,  32'd0);
    add_cmd(OP_START,     32'd200,  32'd0);     // start while running
    add_cmd(OP_LAP,       32'd700,  32'd0);
    add_cmd(OP_RESET,     32'd800,  32'd0);     // reset while running
    add_cmd(OP_PAUSE,     32'd1000, 32'd0);
    add_cmd(OP_START,     32'd1100, 32'd0);     // start while paused
    add_cmd(OP_PAUSE,     32'd1200, 32'd0);     // pause while paused
    add_cmd(OP_STOP,      32'd1300, 32'd0);     // stop while paused
    add_cmd(OP_RESUME,    32'd1500, 32'd0);
    add_cmd(OP_DUR_CHECK, 32'd2000, 32'd0);
    add_cmd(OP_DUR_CHECK, 32'd2001, 32'hFFFF_FFFF);
    add_cmd(OP_TGT_CHECK, 32'd2100, 32'd0);     // no target set
    add_cmd(OP_STOP,      32'hFFFF_FFF0, 32'd0); // elapsed close to the wrap
    add_cmd(OP_LAP,       32'hFFFF_FFF8, 32'd0);
    add_cmd(OP_RESET,     32'hFFFF_FFF9, 32'd0);
    add_cmd(OP_RESTART,   32'hFFFF_FFFF, 32'h5555_5555);
    add_cmd(OP_QUERY,     32'h0000_0010, 32'hAAAA_AAAA); // stamp wrapped
    add_cmd(OpUnusedLo,   32'h0000_0020, 32'd0);
    add_cmd(OpUnusedHi,   32'h0000_0030, 32'd0);
    add_cmd(OP_CLEAR,     32'h0000_0040, 32'd0);
    add_cmd(OP_LAP,       32'h0000_0050, 32'd0); // anchor survives a clear
    drain();

    // Random phases, each under its own register setting.
    write_regs(32'hFFFF_FFFF, 1'b0);
    random_phase(t_now);
    drain();
    write_regs(32'd5000, 1'b1);
    random_phase(t_now);
    drain();
    write_regs(32'd90000, 1'b0);
    random_phase(t_now);
    drain();
    write_regs(32'd7200000, 1'b1);
    random_phase(t_now);
    drain();
    write_regs(32'd1, 1'b1);
    random_phase(t_now);
    drain();
    write_regs($urandom, 1'($urandom_range(0, 1)));
    random_phase(t_now);
    drain();

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/stsw_pkg.sv
hw/rtl/stsw_fifo.sv
hw/rtl/stsw_front.sv
hw/rtl/stsw_exec.sv
hw/rtl/stsw_div.sv
hw/rtl/stopwatch_with_lap_and_target.sv
hw/rtl/stsw_checker.sv
sim/testbench.sv
